>>> src/rt2d_pkg.sv
// Shared types and constants for the 2D rigid transform block.
// No dependencies; imported by rt2d_cordic, rigid_transform_2d_top and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package rt2d_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_HEADING  = 2'd2;
  localparam int         CFG_IDX_W    = 2;

  // Heading in hundredths of a degree
  localparam int HEAD_W       = 16;
  localparam int HALF_TURN    = 18000;
  localparam int FULL_TURN    = 36000;
  localparam int QUARTER_TURN = 9000;

  // CORDIC angle: 2^-16 hundredths of a degree
  localparam int ANGLE_W     = 32;
  localparam int ANGLE_SHIFT = 16;

  // Cosine / sine in Q2.30, carried with a guard bit
  localparam int TRIG_W     = 33;
  localparam int TRIG_MAG_W = 32;
  localparam int TRIG_FRAC  = 30;
  localparam logic signed [TRIG_W-1:0] CORDIC_INV_GAIN = 33'sd652032875;

  localparam int ATAN_IDX_W = 5;
  localparam logic signed [ANGLE_W-1:0] ATAN_TAB [32] = '{
    32'sd294912000, 32'sd174096919, 32'sd91987925, 32'sd46694507,
    32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
    32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183347,
    32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
    32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
    32'sd358,       32'sd179,       32'sd90,       32'sd45,
    32'sd22,        32'sd11,        32'sd6,        32'sd3,
    32'sd1,         32'sd1,         32'sd0,        32'sd0
  };

  typedef enum logic [1:0] {
    TRIG_IDLE,
    TRIG_RUN,
    TRIG_DONE
  } trig_state_t;

  // Cosine and sine of the heading in sign-magnitude form
  typedef struct packed {
    logic                  c_neg;
    logic [TRIG_MAG_W-1:0] c_mag;
    logic                  s_neg;
    logic [TRIG_MAG_W-1:0] s_mag;
  } trig_t;

endpackage

`default_nettype wire

>>> src/rigid_transform_2d_top.sv
// Top level of the 2D rigid transform: config registers, item pipeline, output skid.
// Depends on rt2d_pkg and rt2d_cordic.
//
// Use:
//   Configuration: write origin_x (index 0), origin_y (index 1) and heading
//   (index 2) on cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always
//   high. Write only while no point is in flight. A heading write starts the
//   CORDIC; in_stall is held high until the new cosine and sine are ready.
//   Writes to unused indexes are dropped.
//   Input: a point (func, in_x, in_y) transfers when in_valid is high and
//   in_stall is low. func 0 maps map to body, func 1 body to map.
//   Output: out_x/out_y transfer when out_valid is high and out_stall is low.
//   Throughput: one point per cycle while not stalled; six-stage multiply pipeline.
//   A point passes stages 1 to 6, then the output register that raises out_valid.
//   Stall: the output register is backed by a one-entry skid; while the skid
//   holds a point the pipeline freezes and in_stall is raised, so in_stall
//   depends only on registers, never on out_stall in the same cycle.
//   Reset: rst (synchronous) clears the configuration registers to zero and empties
//   the pipeline, then the CORDIC runs once for heading zero, during which
//   in_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module rigid_transform_2d_top #(
  parameter int COORD_WIDTH   = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [rt2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [COORD_WIDTH-1:0]                cfg_data,
  // input points
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  func,
  input  wire logic signed [COORD_WIDTH-1:0]         in_x,
  input  wire logic signed [COORD_WIDTH-1:0]         in_y,
  // results
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [COORD_WIDTH-1:0]              out_x,
  output logic signed [COORD_WIDTH-1:0]              out_y
);

  import rt2d_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int DW     = CW + 1;           // origin difference
  localparam int LO_W   = CW / 2;           // multiplier split
  localparam int HI_W   = CW - LO_W;
  localparam int PROD_W = CW + TRIG_MAG_W;  // full magnitude product
  localparam int TM_W   = PROD_W - TRIG_FRAC;
  localparam int TS_W   = TM_W + 1;         // signed rounded term
  localparam int RW     = CW + 5;           // final sum
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (TRIG_FRAC - 1);
  localparam logic signed [RW-1:0] SAT_HI = RW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]     origin_x, origin_y;
  logic signed [HEAD_W-1:0] heading;
  logic                     trig_start;
  logic                     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      heading    <= '0;
      trig_start <= 1'b1;  // compute trig for the reset heading
    end else begin
      trig_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: origin_x <= cfg_data;
          REG_ORIGIN_Y: origin_y <= cfg_data;
          REG_HEADING: begin
            heading    <= cfg_data[HEAD_W-1:0];
            trig_start <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  logic  trig_busy;
  trig_t trig;

  rt2d_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (trig_start),
    .heading (heading),
    .busy    (trig_busy),
    .trig    (trig)
  );

  // ---------------------------------------------------------------------------
  // Flow control: the pipeline advances while the skid is empty
  // ---------------------------------------------------------------------------
  logic skid_valid;
  logic advance;
  logic in_take, out_take;

  assign advance  = !skid_valid;
  assign in_stall = trig_busy || skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  logic v1, v2, v3, v4, v5, v6;
  logic f1, f2, f3, f4, f5;

  // Stage 1: subtract the origin for map to body
  logic signed [DW-1:0] ax1, ay1;

  // Stage 2: sign-magnitude of the coordinates
  logic          xn2, yn2;
  logic [CW-1:0] xm2, ym2;

  // Stage 3: partial products; terms are x*c, y*s, y*c, x*s
  logic [HI_W+TRIG_MAG_W-1:0] phi3 [4];
  logic [LO_W+TRIG_MAG_W-1:0] plo3 [4];
  logic                       n3   [4];
  logic [CW-1:0]              am   [4];
  logic [TRIG_MAG_W-1:0]      tm   [4];
  logic                       tn   [4];

  // Stage 4: rounded magnitudes
  logic [TM_W-1:0] m4 [4];
  logic            n4 [4];

  // Stage 5: signed terms
  logic signed [TS_W-1:0] t5 [4];

  // Stage 6: sums
  logic signed [RW-1:0] rx6, ry6;

  always_comb begin
    am[0] = xm2; tm[0] = trig.c_mag; tn[0] = xn2 ^ trig.c_neg;
    am[1] = ym2; tm[1] = trig.s_mag; tn[1] = yn2 ^ trig.s_neg;
    am[2] = ym2; tm[2] = trig.c_mag; tn[2] = yn2 ^ trig.c_neg;
    am[3] = xm2; tm[3] = trig.s_mag; tn[3] = xn2 ^ trig.s_neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= in_take;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 1
      f1 <= func;
      if (func) begin
        ax1 <= DW'(in_x);
        ay1 <= DW'(in_y);
      end else begin
        ax1 <= DW'(in_x) - DW'(origin_x);
        ay1 <= DW'(in_y) - DW'(origin_y);
      end
      // stage 2
      f2  <= f1;
      xn2 <= ax1[DW-1];
      yn2 <= ay1[DW-1];
      xm2 <= CW'(ax1[DW-1] ? -ax1 : ax1);
      ym2 <= CW'(ay1[DW-1] ? -ay1 : ay1);
      // stages 3 to 5, one lane per term
      f3 <= f2;
      f4 <= f3;
      f5 <= f4;
      for (int k = 0; k < 4; k++) begin
        phi3[k] <= am[k][CW-1:LO_W] * tm[k];
        plo3[k] <= am[k][LO_W-1:0] * tm[k];
        n3[k]   <= tn[k];
        m4[k]   <= TM_W'(((PROD_W'(phi3[k]) << LO_W) + PROD_W'(plo3[k]) + RND)
                         >> TRIG_FRAC);
        n4[k]   <= n3[k];
        t5[k]   <= n4[k] ? -$signed({1'b0, m4[k]}) : $signed({1'b0, m4[k]});
      end
      // stage 6: rotate, and add the origin for body to map
      if (f5) begin
        rx6 <= RW'(t5[0]) - RW'(t5[1]) + RW'(origin_x);
        ry6 <= RW'(t5[3]) + RW'(t5[2]) + RW'(origin_y);
      end else begin
        rx6 <= RW'(t5[0]) + RW'(t5[1]);
        ry6 <= RW'(t5[2]) - RW'(t5[3]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturation, output register and skid
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] sat_x, sat_y;
  logic signed [CW-1:0] skid_x, skid_y;
  logic                 push;

  always_comb begin
    if (rx6 > SAT_HI) begin
      sat_x = SAT_HI[CW-1:0];
    end else if (rx6 < SAT_LO) begin
      sat_x = SAT_LO[CW-1:0];
    end else begin
      sat_x = rx6[CW-1:0];
    end
    if (ry6 > SAT_HI) begin
      sat_y = SAT_HI[CW-1:0];
    end else if (ry6 < SAT_LO) begin
      sat_y = SAT_LO[CW-1:0];
    end else begin
      sat_y = ry6[CW-1:0];
    end
  end

  assign push = advance && v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // drain the skid into the output register
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;  // output held: park the point
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_x <= skid_x;
        out_y <= skid_y;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_x <= sat_x;
        out_y <= sat_y;
      end else begin
        skid_x <= sat_x;
        skid_y <= sat_y;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a point while the output register is empty");

  a_heading_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_HEADING) |=> in_stall)
    else $error("points accepted while the heading trig is recomputed");

  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    v6 && !skid_valid && out_valid && out_stall |=> skid_valid)
    else $error("finished point lost while the output was stalled");

endmodule

`default_nettype wire

>>> src/rt2d_cordic.sv
// Iterative CORDIC: cosine and sine of the heading, one stage per cycle.
// Depends on rt2d_pkg (angle table, trig_t, state type).
`timescale 1ns / 1ps
`default_nettype none

module rt2d_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [rt2d_pkg::HEAD_W-1:0] heading,
  output logic                                    busy,
  output rt2d_pkg::trig_t                         trig
);

  import rt2d_pkg::*;

  localparam int             CNT_W = $clog2(STAGES);
  localparam int             HW    = HEAD_W + 2;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STAGES - 1);

  trig_state_t state, state_next;

  logic signed [TRIG_W-1:0]  x, y;
  logic signed [ANGLE_W-1:0] z;
  logic                      flip;
  logic [CNT_W-1:0]          cnt;

  logic signed [HW-1:0]      h_wide, h_wrap, h_fold;
  logic                      flip_init;
  logic signed [ANGLE_W-1:0] z_init;
  logic signed [TRIG_W-1:0]  dx, dy;
  logic signed [ANGLE_W-1:0] atan;

  // Wrap into one turn, then fold by a half turn beyond a quarter turn
  always_comb begin
    h_wide = HW'(heading);
    if (h_wide >= HW'(HALF_TURN)) begin
      h_wrap = h_wide - HW'(FULL_TURN);
    end else if (h_wide < -HW'(HALF_TURN)) begin
      h_wrap = h_wide + HW'(FULL_TURN);
    end else begin
      h_wrap = h_wide;
    end
    flip_init = 1'b0;
    h_fold    = h_wrap;
    if (h_wrap > HW'(QUARTER_TURN)) begin
      h_fold    = h_wrap - HW'(HALF_TURN);
      flip_init = 1'b1;
    end else if (h_wrap < -HW'(QUARTER_TURN)) begin
      h_fold    = h_wrap + HW'(HALF_TURN);
      flip_init = 1'b1;
    end
    z_init = ANGLE_W'(h_fold) <<< ANGLE_SHIFT;
  end

  always_comb begin
    dx   = y >>> cnt;
    dy   = x >>> cnt;
    atan = ATAN_TAB[ATAN_IDX_W'(cnt)];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      TRIG_IDLE: state_next = TRIG_IDLE;
      TRIG_RUN:  if (cnt == LAST) begin
        state_next = TRIG_DONE;
      end
      TRIG_DONE: state_next = TRIG_IDLE;
      default:   state_next = TRIG_IDLE;
    endcase
    if (start) begin
      state_next = TRIG_RUN;
    end
  end

  // Outputs
  always_comb begin
    case (state)
      TRIG_IDLE: busy = start;
      TRIG_RUN:  busy = 1'b1;
      TRIG_DONE: busy = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TRIG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_INV_GAIN;
      y    <= '0;
      z    <= z_init;
      flip <= flip_init;
      cnt  <= '0;
    end else if (state == TRIG_RUN) begin
      if (z >= 0) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - atan;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + atan;
      end
      cnt <= cnt + 1'b1;
    end
  end

  // Convert to sign-magnitude; the fold negates both
  always_ff @(posedge clk) begin
    if (state == TRIG_DONE) begin
      trig.c_neg <= x[TRIG_W-1] ^ flip;
      trig.s_neg <= y[TRIG_W-1] ^ flip;
      trig.c_mag <= TRIG_MAG_W'(x[TRIG_W-1] ? -x : x);
      trig.s_mag <= TRIG_MAG_W'(y[TRIG_W-1] ? -y : y);
    end
  end

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == TRIG_RUN) && (cnt == '0))
    else $error("CORDIC did not restart on request");

  a_done_once: assert property (@(posedge clk) disable iff (rst)
    (state == TRIG_DONE) && !start |=> (state == TRIG_IDLE))
    else $error("CORDIC stayed in its final stage");

  a_busy_cover: assert property (@(posedge clk) disable iff (rst)
    (state != TRIG_IDLE) |-> busy)
    else $error("CORDIC working while not busy");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the 2D rigid transform (rigid_transform_2d_top).
// Depends on rt2d_pkg for the register indexes and turn constants.
// It predicts every point in fixed point alongside the block, CORDIC included.
`timescale 1ns / 1ps

module testbench;
  import rt2d_pkg::*;

  localparam int COORD_W  = 32;
  localparam int CORDIC_N = 16;
  localparam longint COORD_HI = (longint'(1) << (COORD_W - 1)) - 1;
  localparam longint COORD_LO = -COORD_HI - 1;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

  localparam logic FUNC_MAP_TO_BODY = 1'b0;
  localparam logic FUNC_BODY_TO_MAP = 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int DRAIN_CYCLES   = 12;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  // 1/K of the CORDIC gain in Q2.30, and atan(2^-i) in 2^-16 centidegrees
  localparam longint INV_GAIN_Q30 = 652032875;
  localparam longint ARCTAN_STEP [32] = '{
    294912000, 174096919, 91987925, 46694507, 23437865, 11730358,
    5866610, 2933484, 1466764, 733385, 366693, 183347, 91673, 45837,
    22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11,
    6, 3, 1, 1, 0, 0
  };

  localparam int FOLD_CASES [3]    = '{9000, 9001, -9001};
  localparam int HEADING_EDGES [8] = '{18000, -18000, 9000, -9000, 9001, -9001, 0, -1};
  localparam int SEND_MIX [4]      = '{0, 71, 0, 12};
  localparam int RECV_MIX [4]      = '{0, 0, 71, 12};

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } coord_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [COORD_W-1:0]        cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic                      func      = 1'b0;
  logic signed [COORD_W-1:0] in_x      = '0;
  logic signed [COORD_W-1:0] in_y      = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;

  // Pose as the block should hold it, with cosine and sine in Q2.30
  longint pose_x = 0, pose_y = 0, pose_cos = 0, pose_sin = 0;

  point_t      pending_points[$];
  coord_pair_t predicted_points[$];
  point_t      next_point;
  logic        point_taken = 1'b0;
  coord_pair_t want;

  int errors = 0, results_checked = 0, m2b_points = 0, b2m_points = 0;
  int cfg_writes = 0, heading_writes = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_request = 0, hold_served = 0, hold_left = 0;
  int quiet_cycles = 0;

  rigid_transform_2d_top #(
    .COORD_WIDTH   (COORD_W),
    .CORDIC_STAGES (CORDIC_N)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .in_x      (in_x),
    .in_y      (in_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Cosine and sine of a heading in centidegrees, Q2.30
  function automatic void heading_trig(input logic signed [15:0] hd,
                                       output longint c, output longint s);
    longint h, x, y, z, dx, dy;
    bit     flip;
    h    = hd;
    x    = INV_GAIN_Q30;
    y    = 0;
    flip = 1'b0;
    // Reduce into [-180, 180) degrees, then fold anything past a quarter turn
    if (h >= HALF_TURN) h -= FULL_TURN;
    if (h < -HALF_TURN) h += FULL_TURN;
    if (h > QUARTER_TURN) begin
      h -= HALF_TURN;
      flip = 1'b1;
    end else if (h < -QUARTER_TURN) begin
      h += HALF_TURN;
      flip = 1'b1;
    end
    z = h * 65536;
    for (int i = 0; i < CORDIC_N && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_STEP[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_STEP[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Q16.16 times Q2.30, rounded half away from zero back to Q16.16
  function automatic longint scale_q30(input longint a, input longint b);
    bit           neg;
    logic [127:0] ua, ub, prod;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = (ua * ub + (128'd1 << 29)) >> 30;
    return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
    if (v > COORD_HI) return C_MAX;
    if (v < COORD_LO) return C_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic coord_pair_t transform_point(input logic f,
                                                  input logic signed [COORD_W-1:0] x,
                                                  input logic signed [COORD_W-1:0] y);
    longint      px, py, rx, ry;
    coord_pair_t r;
    px = x;
    py = y;
    if (f == FUNC_MAP_TO_BODY) begin
      px -= pose_x;
      py -= pose_y;
      rx = scale_q30(px, pose_cos) + scale_q30(py, pose_sin);
      ry = scale_q30(py, pose_cos) - scale_q30(px, pose_sin);
    end else begin
      rx = scale_q30(px, pose_cos) - scale_q30(py, pose_sin) + pose_x;
      ry = scale_q30(px, pose_sin) + scale_q30(py, pose_cos) + pose_y;
    end
    r.x = clamp_coord(rx);
    r.y = clamp_coord(ry);
    return r;
  endfunction

  // Mostly full-range and small values, with the extremes mixed in
  function automatic logic signed [COORD_W-1:0] pick_coord();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0: return C_MAX;
      1: return C_MIN;
      2: return $urandom_range(1) ? -32'sd1 : 32'sd0;
      3, 4, 5: return $urandom;
      default: return int'($urandom_range(2097152)) - 1048576;
    endcase
  endfunction

  // Point driver: present the next pending point once the previous one has transferred
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || point_taken) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_point = pending_points.pop_front();
        func     <= next_point.func;
        in_x     <= next_point.x;
        in_y     <= next_point.y;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold whenever one is requested
  always @(negedge clk) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check each output transfer in order
  always @(posedge clk) begin
    point_taken <= in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      predicted_points.push_back(transform_point(func, in_x, in_y));
      if (func == FUNC_MAP_TO_BODY) m2b_points++;
      else b2m_points++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (predicted_points.size() == 0) begin
        $error("result transfer with nothing outstanding: out_x %0d out_y %0d", out_x, out_y);
        errors++;
      end else begin
        want = predicted_points.pop_front();
        if (out_x !== want.x) begin
          $error("out_x: expected %0d, got %0d", want.x, out_x);
          errors++;
        end
        if (out_y !== want.y) begin
          $error("out_y: expected %0d, got %0d", want.y, out_y);
          errors++;
        end
        results_checked++;
      end
    end
  end

  // Watchdog: end the run if no channel transfers for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transfer", quiet_cycles);
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register and mirror it into the predicted pose
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_ORIGIN_X: pose_x = longint'($signed(data));
      REG_ORIGIN_Y: pose_y = longint'($signed(data));
      REG_HEADING: begin
        heading_trig(data[15:0], pose_cos, pose_sin);
        heading_writes++;
      end
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_point(input logic f, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    point_t p;
    p.func = f;
    p.x    = x;
    p.y    = y;
    pending_points.push_back(p);
  endtask

  // Wait until every point has come back, then let the pipeline settle
  task automatic drain();
    while (pending_points.size() != 0 || in_valid || predicted_points.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_pose();
    logic [15:0] hd;
    int unsigned pick;
    write_reg(REG_ORIGIN_X, pick_coord());
    write_reg(REG_ORIGIN_Y, pick_coord());
    pick = $urandom_range(9);
    if (pick < 7) hd = 16'(int'($urandom_range(2 * HALF_TURN)) - HALF_TURN);
    else if (pick < 9) hd = 16'(HEADING_EDGES[$urandom_range(7)]);
    else hd = 16'($urandom);
    // Upper data bits are junk; only the low 16 bits count for the heading
    write_reg(REG_HEADING, {16'($urandom), hd});
    write_reg(REG_SPARE, $urandom);
  endtask

  task automatic run_points(input int send_pct, input int recv_pct, input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) push_point(1'($urandom_range(1)), pick_coord(), pick_coord());
    drain();
  endtask

  initial begin
    heading_trig(16'sd0, pose_cos, pose_sin);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset pose is the identity: coordinate extremes in both directions
    push_point(FUNC_MAP_TO_BODY, C_MAX, C_MIN);
    push_point(FUNC_BODY_TO_MAP, C_MIN, C_MAX);
    push_point(FUNC_MAP_TO_BODY, 32'sd0, -32'sd1);
    push_point(FUNC_BODY_TO_MAP, -32'sd1, 32'sd65536);
    drain();

    // Half turn with the origin in opposite corners: the first point saturates both outputs
    write_reg(REG_ORIGIN_X, C_MIN);
    write_reg(REG_ORIGIN_Y, C_MAX);
    write_reg(REG_HEADING, 32'(HALF_TURN));
    push_point(FUNC_MAP_TO_BODY, C_MAX, C_MIN);
    push_point(FUNC_BODY_TO_MAP, C_MAX, C_MAX);
    push_point(FUNC_MAP_TO_BODY, 32'sd0, 32'sd0);
    push_point(FUNC_BODY_TO_MAP, C_MIN, 32'sd0);
    drain();

    write_reg(REG_ORIGIN_X, C_MAX);
    write_reg(REG_ORIGIN_Y, C_MIN);
    write_reg(REG_HEADING, 32'(-HALF_TURN));
    push_point(FUNC_MAP_TO_BODY, C_MIN, C_MAX);
    push_point(FUNC_BODY_TO_MAP, C_MAX, C_MIN);
    push_point(FUNC_BODY_TO_MAP, -32'sd65536, 32'sd65536);
    drain();

    // Quarter turn exactly, and just past it where the angle gets folded
    write_reg(REG_ORIGIN_X, 32'sd327680);
    write_reg(REG_ORIGIN_Y, -32'sd131072);
    foreach (FOLD_CASES[i]) begin
      write_reg(REG_HEADING, 32'(FOLD_CASES[i]));
      push_point(FUNC_MAP_TO_BODY, 32'sd6553600, -32'sd3276800);
      push_point(FUNC_BODY_TO_MAP, -32'sd6553600, 32'sd3276800);
      drain();
    end

    // Most negative 16-bit heading, junk in the upper bits, then a dropped write
    write_reg(REG_HEADING, 32'hABCD_8000);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    push_point(FUNC_MAP_TO_BODY, 32'sd1, 32'sd1);
    push_point(FUNC_BODY_TO_MAP, C_MAX, C_MAX);
    drain();

    // Most positive 16-bit heading, well beyond a half turn
    write_reg(REG_HEADING, 32'h0000_7FFF);
    push_point(FUNC_MAP_TO_BODY, C_MIN, C_MIN);
    push_point(FUNC_BODY_TO_MAP, 32'sd65536, -32'sd65536);
    drain();

    // Random pose and points under each idling mix
    foreach (SEND_MIX[m]) begin
      repeat (2) begin
        random_pose();
        run_points(SEND_MIX[m], RECV_MIX[m], 100);
      end
    end

    // Hold the output off for a long stretch while points keep arriving
    random_pose();
    hold_request++;
    run_points(0, 0, 40);

    $display("summary: %0d results checked (%0d map to body, %0d body to map)",
             results_checked, m2b_points, b2m_points);
    $display("summary: %0d register writes, %0d headings, idle mixes none/send/receive/both",
             cfg_writes, heading_writes);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
